// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Property checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/ssrr_pkg.sv -----
// Shared constants, types and pipeline payloads of the smoothstep remap block
package ssrr_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int SAMPLE_WIDTH = 24;
  localparam int ONE_W        = FRAC_BITS + 1;
  localparam int COEF_W       = FRAC_BITS + 4;

  localparam logic [ONE_W-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic {
    CURVE_CUBIC   = 1'b0,
    CURVE_QUINTIC = 1'b1
  } curve_t;

  // Per-item control carried down the whole pipe; lo holds the result on bypass
  typedef struct packed {
    logic                           byp;
    curve_t                         order;
    logic signed [SAMPLE_WIDTH-1:0] lo;
    logic        [SAMPLE_WIDTH-1:0] span;
  } ctl_t;

  typedef struct packed {
    ctl_t                    ctl;
    logic                    full;
    logic [SAMPLE_WIDTH-1:0] rem;
    logic [FRAC_BITS-1:0]    q;
  } div_t;

endpackage

// ----- hw/rtl/smoothstep_range_remap.sv -----
// Smoothstep range remap: takes one sample with its own bounds on every cycle while
// the result side keeps up, and returns one result per sample, in order. The pipeline
// has twenty-two register stages: one input stage, sixteen divider stages of one
// quotient bit each, three curve multiply stages and two rescale stages. Each stage
// holds its item while the next is full, so a stall at the result port fills bubbles
// before item_ready drops. curve_order (0 cubic, 1 quintic) is taken on the cfg port,
// which is always ready, and must be written while idle.
module smoothstep_range_remap import ssrr_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [SAMPLE_WIDTH-1:0] lower_bound,
  input  logic signed [SAMPLE_WIDTH-1:0] upper_bound,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic signed [SAMPLE_WIDTH-1:0] remapped,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           curve_order
);

  curve_t           curve_sel;
  logic             div_valid [FRAC_BITS+1];
  logic             div_ready [FRAC_BITS+1];
  div_t             div_data  [FRAC_BITS+1];
  logic             shp_valid;
  logic             shp_ready;
  ctl_t             shp_ctl;
  logic [ONE_W-1:0] shp_s;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_sel <= CURVE_CUBIC;
    end else if (cfg_valid) begin
      curve_sel <= curve_t'(curve_order);
    end
  end

  ssrr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sample     (sample),
    .lower_bound(lower_bound),
    .upper_bound(upper_bound),
    .order      (curve_sel),
    .dn_valid   (div_valid[0]),
    .dn_data    (div_data[0]),
    .dn_ready   (div_ready[0])
  );

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    ssrr_div_stage u_div (
      .clk     (clk),
      .rst     (rst),
      .up_valid(div_valid[i]),
      .up_ready(div_ready[i]),
      .up_data (div_data[i]),
      .dn_valid(div_valid[i+1]),
      .dn_data (div_data[i+1]),
      .dn_ready(div_ready[i+1])
    );
  end

  ssrr_shape u_shape (
    .clk     (clk),
    .rst     (rst),
    .up_valid(div_valid[FRAC_BITS]),
    .up_ready(div_ready[FRAC_BITS]),
    .up_data (div_data[FRAC_BITS]),
    .dn_valid(shp_valid),
    .dn_ctl  (shp_ctl),
    .dn_s    (shp_s),
    .dn_ready(shp_ready)
  );

  ssrr_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (shp_valid),
    .up_ready    (shp_ready),
    .up_ctl      (shp_ctl),
    .up_s        (shp_s),
    .result_valid(result_valid),
    .remapped    (remapped),
    .result_ready(result_ready)
  );

endmodule

// ----- hw/rtl/ssrr_front.sv -----
// Input stage: bound checks, span and offset, divider set-up
module ssrr_front import ssrr_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [SAMPLE_WIDTH-1:0] lower_bound,
  input  logic signed [SAMPLE_WIDTH-1:0] upper_bound,
  input  curve_t                         order,
  output logic                           dn_valid,
  output div_t                           dn_data,
  input  logic                           dn_ready
);

  logic                         below;
  logic                         above;
  logic                         same;
  logic signed [SAMPLE_WIDTH:0] span_ext;
  logic signed [SAMPLE_WIDTH:0] off_ext;
  logic [SAMPLE_WIDTH-1:0]      span;
  logic [SAMPLE_WIDTH-1:0]      off;
  logic                         load;
  div_t                         item;

  assign below    = sample < lower_bound;
  assign above    = sample > upper_bound;
  assign same     = upper_bound == lower_bound;
  assign span_ext = {upper_bound[SAMPLE_WIDTH-1], upper_bound}
                  - {lower_bound[SAMPLE_WIDTH-1], lower_bound};
  assign off_ext  = {sample[SAMPLE_WIDTH-1], sample}
                  - {lower_bound[SAMPLE_WIDTH-1], lower_bound};
  assign span     = span_ext[SAMPLE_WIDTH-1:0];
  assign off      = off_ext[SAMPLE_WIDTH-1:0];

  always_comb begin
    item.ctl.byp   = below | above | same;
    item.ctl.order = order;
    item.ctl.lo    = above && !below ? upper_bound : lower_bound;
    item.ctl.span  = span;
    // sample on the upper bound gives exactly one
    item.full      = off >= span;
    item.rem       = off;
    item.q         = '0;
  end

  assign load       = !dn_valid || dn_ready;
  assign item_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (load) begin
      dn_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && item_valid) begin
      dn_data <= item;
    end
  end

endmodule

// ----- hw/rtl/ssrr_div_stage.sv -----
// One quotient bit of the pipelined restoring divider
module ssrr_div_stage import ssrr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  div_t up_data,
  output logic dn_valid,
  output div_t dn_data,
  input  logic dn_ready
);

  logic [SAMPLE_WIDTH:0] shifted;
  logic [SAMPLE_WIDTH:0] diff;
  logic                  take;
  logic                  load;
  div_t                  nxt;

  assign shifted = {up_data.rem, 1'b0};
  assign diff    = shifted - {1'b0, up_data.ctl.span};
  assign take    = shifted >= {1'b0, up_data.ctl.span};

  always_comb begin
    nxt = up_data;
    if (!up_data.full && !up_data.ctl.byp) begin
      nxt.rem = take ? diff[SAMPLE_WIDTH-1:0] : shifted[SAMPLE_WIDTH-1:0];
      nxt.q   = {up_data.q[FRAC_BITS-2:0], take};
    end
  end

  assign load     = !dn_valid || dn_ready;
  assign up_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (load) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      dn_data <= nxt;
    end
  end

endmodule

// ----- hw/rtl/ssrr_shape.sv -----
// Three multiply stages that evaluate the cubic or quintic curve and clamp it
module ssrr_shape import ssrr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  div_t             up_data,
  output logic             dn_valid,
  output ctl_t             dn_ctl,
  output logic [ONE_W-1:0] dn_s,
  input  logic             dn_ready
);

  localparam logic [COEF_W-1:0] THREE_FX   = COEF_W'(3) << FRAC_BITS;
  localparam logic [COEF_W-1:0] TEN_FX     = COEF_W'(10) << FRAC_BITS;
  localparam logic [COEF_W-1:0] FIFTEEN_FX = COEF_W'(15) << FRAC_BITS;
  localparam int T2_W = 2 * ONE_W;
  localparam int XC_W = ONE_W + COEF_W;

  typedef struct packed {
    ctl_t              ctl;
    logic [ONE_W-1:0]  t;
    logic [ONE_W-1:0]  t2;
    logic [COEF_W-1:0] coef;
  } sh1_t;

  typedef struct packed {
    ctl_t              ctl;
    logic [COEF_W-1:0] x;
    logic [COEF_W-1:0] m;
  } sh2_t;

  // stage 1: t, t^2 and the linear coefficient
  logic [ONE_W-1:0]  t;
  logic [T2_W-1:0]   tt;
  logic [COEF_W-1:0] t_ext;
  sh1_t              s1_next;
  sh1_t              s1;
  logic              v1;
  logic              load1;

  assign t     = up_data.full ? ONE_FX : {1'b0, up_data.q};
  assign tt    = t * t;
  assign t_ext = {{(COEF_W-ONE_W){1'b0}}, t};

  always_comb begin
    s1_next.ctl = up_data.ctl;
    s1_next.t   = t;
    s1_next.t2  = tt[FRAC_BITS +: ONE_W];
    case (up_data.ctl.order)
      CURVE_CUBIC:   s1_next.coef = THREE_FX - (t_ext << 1);
      CURVE_QUINTIC: s1_next.coef = FIFTEEN_FX - (t_ext << 2) - (t_ext << 1);
      default:       s1_next.coef = THREE_FX - (t_ext << 1);
    endcase
  end

  // stage 2: cubic finishes here; quintic forms t^3 and t*(15-6t)
  logic [T2_W-1:0] t2t;
  logic [XC_W-1:0] t2c;
  logic [XC_W-1:0] tc;
  sh2_t            s2_next;
  sh2_t            s2;
  logic            v2;
  logic            load2;

  assign t2t = s1.t2 * s1.t;
  assign t2c = s1.t2 * s1.coef;
  assign tc  = s1.t * s1.coef;

  always_comb begin
    s2_next.ctl = s1.ctl;
    s2_next.m   = tc[FRAC_BITS +: COEF_W];
    case (s1.ctl.order)
      CURVE_CUBIC:   s2_next.x = t2c[FRAC_BITS +: COEF_W];
      CURVE_QUINTIC: s2_next.x = {{(COEF_W-ONE_W){1'b0}}, t2t[FRAC_BITS +: ONE_W]};
      default:       s2_next.x = t2c[FRAC_BITS +: COEF_W];
    endcase
  end

  // stage 3: quintic t^3*(10 - m), then limit to one
  logic [COEF_W-1:0]  qcoef;
  logic [XC_W-1:0]    xq;
  logic [XC_W-1:0]    shaped;
  logic [ONE_W-1:0]   s3_next;
  logic               load3;

  assign qcoef = TEN_FX - s2.m;
  assign xq    = s2.x[ONE_W-1:0] * qcoef;

  always_comb begin
    case (s2.ctl.order)
      CURVE_CUBIC:   shaped = {{ONE_W{1'b0}}, s2.x};
      CURVE_QUINTIC: shaped = {{FRAC_BITS{1'b0}}, xq[XC_W-1:FRAC_BITS]};
      default:       shaped = {{ONE_W{1'b0}}, s2.x};
    endcase
    s3_next = shaped > XC_W'(ONE_FX) ? ONE_FX : shaped[ONE_W-1:0];
  end

  assign load3    = !dn_valid || dn_ready;
  assign load2    = !v2 || load3;
  assign load1    = !v1 || load2;
  assign up_ready = load1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (load1) v1 <= up_valid;
      if (load2) v2 <= v1;
      if (load3) dn_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (load1 && up_valid) s1 <= s1_next;
    if (load2 && v1) s2 <= s2_next;
    if (load3 && v2) begin
      dn_ctl <= s2.ctl;
      dn_s   <= s3_next;
    end
  end

endmodule

// ----- hw/rtl/ssrr_scale.sv -----
// Rescale the shaped value into the range and drive the result register
module ssrr_scale import ssrr_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  ctl_t                           up_ctl,
  input  logic [ONE_W-1:0]               up_s,
  output logic                           result_valid,
  output logic signed [SAMPLE_WIDTH-1:0] remapped,
  input  logic                           result_ready
);

  localparam int P_W = SAMPLE_WIDTH + ONE_W;

  logic [P_W-1:0]          prod;
  ctl_t                    ctl4;
  logic [SAMPLE_WIDTH-1:0] part;
  logic                    v4;
  logic                    load4;
  logic                    load5;
  logic [SAMPLE_WIDTH:0]   sum;

  assign prod = up_ctl.span * up_s;
  assign sum  = {ctl4.lo[SAMPLE_WIDTH-1], ctl4.lo} + {1'b0, part};

  assign load5    = !result_valid || result_ready;
  assign load4    = !v4 || load5;
  assign up_ready = load4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (load4) v4 <= up_valid;
      if (load5) result_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (load4 && up_valid) begin
      ctl4 <= up_ctl;
      part <= prod[FRAC_BITS +: SAMPLE_WIDTH];
    end
    // bypass carries its answer in lo
    if (load5 && v4) begin
      remapped <= ctl4.byp ? ctl4.lo : sum[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

// ----- hw/rtl/ssrr_checker.sv -----
// Port-level checks of the smoothstep remap block, bound to the top level
`include "assert_macros.svh"

module ssrr_checker import ssrr_pkg::*; (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_valid,
  input logic                           item_ready,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic signed [SAMPLE_WIDTH-1:0] remapped,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);

  // hold a stalled result
  `ASSERT_CLK(a_result_held, clk, rst, result_valid && !result_ready |=> result_valid)
  `ASSERT_CLK(a_result_stable, clk, rst, result_valid && !result_ready |=> $stable(remapped))
  // an empty result register means every stage can advance
  `ASSERT_CLK(a_ready_when_empty, clk, rst, !result_valid |-> item_ready)
  `ASSERT_CLK(a_cfg_always_ready, clk, rst, cfg_valid |-> cfg_ready)
  `ASSERT_CLK(a_empty_after_reset, clk, rst, $past(rst) |-> !result_valid)

endmodule

bind smoothstep_range_remap ssrr_checker u_ssrr_checker (.*);

// ----- bench/tb_smoothstep_range_remap.sv -----
// Testbench for the smoothstep range remap block: queued stimulus, bit-exact prediction
`timescale 1ns / 100ps

module tb_smoothstep_range_remap;
  import ssrr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 30;
  localparam int FIELD_MIN   = -(1 << (SAMPLE_WIDTH - 1));
  localparam int FIELD_MAX   = (1 << (SAMPLE_WIDTH - 1)) - 1;
  localparam longint unsigned UNIT = 64'd1 << FRAC_BITS;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] sample;
    logic [SAMPLE_WIDTH-1:0] lower;
    logic [SAMPLE_WIDTH-1:0] upper;
  } remap_req_t;

  logic                           clk;
  logic                           rst          = 1'b1;
  logic                           item_valid   = 1'b0;
  logic                           item_ready;
  logic signed [SAMPLE_WIDTH-1:0] sample       = '0;
  logic signed [SAMPLE_WIDTH-1:0] lower_bound  = '0;
  logic signed [SAMPLE_WIDTH-1:0] upper_bound  = '0;
  logic                           result_valid;
  logic                           result_ready = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] remapped;
  logic                           cfg_valid    = 1'b0;
  logic                           cfg_ready;
  logic                           curve_order  = 1'b0;

  remap_req_t              pending_items[$];
  logic [SAMPLE_WIDTH-1:0] expected_remap[$];

  curve_t curve_setting  = CURVE_CUBIC;
  int     send_gap_max   = 0;
  int     recv_gap_max   = 0;
  int     send_wait      = 0;
  int     recv_wait      = 0;
  int     mismatch_count = 0;
  int     cycle_count    = 0;
  int     holds_asked    = 0;
  int     holds_done     = 0;
  int     hold_left      = 0;

  smoothstep_range_remap i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .sample       (sample),
    .lower_bound  (lower_bound),
    .upper_bound  (upper_bound),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .remapped     (remapped),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .curve_order  (curve_order)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp, normalise, shape and rescale exactly as the fixed-point datapath does
  function automatic logic [SAMPLE_WIDTH-1:0] smoothstep_remap(
    input logic signed [SAMPLE_WIDTH-1:0] x,
    input logic signed [SAMPLE_WIDTH-1:0] lo,
    input logic signed [SAMPLE_WIDTH-1:0] hi,
    input curve_t                         curve
  );
    longint          xs, ls, hs, res;
    longint unsigned span, t, t2, t3, m, s;
    xs = x;
    ls = lo;
    hs = hi;
    if (xs < ls) return lo;
    if (xs > hs) return hi;
    if (hs == ls) return lo;
    span = hs - ls;
    t    = ((xs - ls) << FRAC_BITS) / span;
    t2   = (t * t) >> FRAC_BITS;
    if (curve == CURVE_QUINTIC) begin
      t3 = (t2 * t) >> FRAC_BITS;
      m  = (t * (15 * UNIT - 6 * t)) >> FRAC_BITS;
      s  = (t3 * (10 * UNIT - m)) >> FRAC_BITS;
    end else begin
      s = (t2 * (3 * UNIT - 2 * t)) >> FRAC_BITS;
    end
    if (s > UNIT) s = UNIT;
    res = ls + longint'((span * s) >> FRAC_BITS);
    return res[SAMPLE_WIDTH-1:0];
  endfunction

  function automatic int rand_field();
    rand_field = $urandom_range(0, (1 << SAMPLE_WIDTH) - 1) + FIELD_MIN;
  endfunction

  task automatic queue_item(input int s, input int l, input int h);
    remap_req_t r;
    r.sample = s[SAMPLE_WIDTH-1:0];
    r.lower  = l[SAMPLE_WIDTH-1:0];
    r.upper  = h[SAMPLE_WIDTH-1:0];
    pending_items.push_back(r);
  endtask

  task automatic queue_directed();
    queue_item(FIELD_MIN, FIELD_MIN, FIELD_MAX);
    queue_item(FIELD_MAX, FIELD_MIN, FIELD_MAX);
    queue_item(0, FIELD_MIN, FIELD_MAX);
    queue_item(4194304, FIELD_MIN, FIELD_MAX);
    queue_item(-5592405, FIELD_MIN, FIELD_MAX);
    queue_item(FIELD_MIN, 0, 65536);
    queue_item(FIELD_MAX, -65536, 65536);
    queue_item(0, 0, 0);
    queue_item(FIELD_MIN, FIELD_MIN, FIELD_MIN);
    queue_item(FIELD_MAX, FIELD_MAX, FIELD_MAX);
    // inverted bounds: between or under lower stays lower, on lower goes to upper
    queue_item(0, 65536, -65536);
    queue_item(-131072, 65536, -65536);
    queue_item(65536, 65536, -65536);
    queue_item(32768, 0, 65536);
    queue_item(0, 0, 1);
    queue_item(1, 0, 1);
    queue_item(1, 0, 3);
    queue_item(2, 0, 3);
    queue_item(FIELD_MAX - 1, 0, FIELD_MAX);
    queue_item(-1, -2, 0);
  endtask

  task automatic queue_random(input int count);
    int k, l, h, v, tmp;
    repeat (count) begin
      k = $urandom_range(0, 99);
      l = rand_field();
      h = rand_field();
      if (l > h) begin
        tmp = l;
        l   = h;
        h   = tmp;
      end
      if (k < 60) begin
        v = l + int'($urandom % (h - l + 1));
      end else if (k < 75) begin
        // narrow span, lands on the bounds often
        l = $urandom_range(0, (1 << SAMPLE_WIDTH) - 65) + FIELD_MIN;
        h = l + $urandom_range(1, 64);
        v = l + int'($urandom % (h - l + 1));
      end else if (k < 82) begin
        v = (l > FIELD_MIN) ? l - 1 - int'($urandom % (l - FIELD_MIN)) : l;
      end else if (k < 89) begin
        v = (h < FIELD_MAX) ? h + 1 + int'($urandom % (FIELD_MAX - h)) : h;
      end else if (k < 94) begin
        h = l;
        v = ($urandom_range(0, 1) != 0) ? l : rand_field();
      end else begin
        // unordered fields, inverted bounds included
        v = rand_field();
        l = rand_field();
        h = rand_field();
      end
      queue_item(v, l, h);
    end
  endtask

  task automatic write_curve(input curve_t c);
    @(posedge clk);
    cfg_valid   <= 1'b1;
    curve_order <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    curve_setting = c;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_remap.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input curve_t c, input int sgap, input int rgap,
                           input int count, input bit long_hold);
    write_curve(c);
    send_gap_max = sgap;
    recv_gap_max = rgap;
    queue_random(count);
    if (long_hold) begin
      @(posedge clk);
      holds_asked <= holds_asked + 1;
    end
    drain();
  endtask

  // Sender: present queued items, draw an idle gap after each transaction
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_wait  = 0;
    end else if (!item_valid || item_ready) begin
      if (item_valid) begin
        expected_remap.push_back(
          smoothstep_remap(sample, lower_bound, upper_bound, curve_setting));
        void'(pending_items.pop_front());
        send_wait = $urandom_range(0, send_gap_max);
      end
      if (send_wait != 0) begin
        send_wait--;
        item_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        item_valid  <= 1'b1;
        sample      <= pending_items[0].sample;
        lower_bound <= pending_items[0].lower;
        upper_bound <= pending_items[0].upper;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver: check each transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      recv_wait    = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_remap.size() == 0) begin
          $display("%0t: unexpected result, actual %0d", $time, remapped);
          mismatch_count++;
        end else begin
          if (remapped !== expected_remap[0]) begin
            $display("%0t: remapped mismatch, expected %0d, actual %0d", $time,
                     $signed(expected_remap[0]), remapped);
            mismatch_count++;
          end
          void'(expected_remap.pop_front());
        end
        recv_wait = $urandom_range(0, recv_gap_max);
      end else if (!result_ready && recv_wait != 0) begin
        recv_wait--;
      end
      result_ready <= (recv_wait == 0) && (hold_left == 0);
    end
  end

  // Long hold-off of the result side, so the pipe fills and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (holds_done != holds_asked) begin
      hold_left  <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_curve(CURVE_CUBIC);
    queue_directed();
    drain();
    write_curve(CURVE_QUINTIC);
    send_gap_max = 2;
    recv_gap_max = 2;
    queue_directed();
    drain();

    run_phase(CURVE_CUBIC,   0, 0, 200, 1'b0);
    run_phase(CURVE_QUINTIC, 6, 6, 200, 1'b0);
    run_phase(CURVE_CUBIC,   0, 6, 200, 1'b0);
    run_phase(CURVE_QUINTIC, 6, 0, 200, 1'b0);
    run_phase(CURVE_QUINTIC, 0, 0, 200, 1'b1);
    run_phase(CURVE_CUBIC,   3, 3, 200, 1'b0);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_remap.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
